@@ rtl/mtf_pkg.sv @@
// ----------------------------------------------------------------------------
// mtf_pkg
// Shared widths, codes and defaults for the move-to-front key table.
// ----------------------------------------------------------------------------
package mtf_pkg;

  localparam int KEY_W        = 48;
  localparam int FUNC_W       = 2;
  localparam int POS_W        = 6;
  localparam int STAT_W       = 3;
  localparam int CNT_W        = 7;
  localparam int MTF_CAPACITY = 64;

  // operation codes; any code with bit 1 set is a read
  localparam logic [FUNC_W-1:0] FN_ADD   = 2'd0;
  localparam logic [FUNC_W-1:0] FN_CLEAR = 2'd1;

  typedef enum logic [STAT_W-1:0] {
    ST_ADDED   = 3'd0,
    ST_DUP     = 3'd1,
    ST_FULL    = 3'd2,
    ST_CLEARED = 3'd3,
    ST_READ    = 3'd4
  } status_t;

endpackage

@@ rtl/mtf_if.sv @@
// ----------------------------------------------------------------------------
// mtf_if
// Request and response channels of the key table (valid/ready).
// ----------------------------------------------------------------------------
interface mtf_in_if
  import mtf_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [KEY_W-1:0]  key;
  logic [POS_W-1:0]  position;

  modport source (output valid, func, key, position, input ready);
  modport sink   (input valid, func, key, position, output ready);
endinterface

interface mtf_out_if
  import mtf_pkg::*;
();
  logic             valid;
  logic             ready;
  status_t          status;
  logic [KEY_W-1:0] key_out;
  logic             entry_valid;
  logic [CNT_W-1:0] entry_count;

  modport source (output valid, status, key_out, entry_valid, entry_count, input ready);
  modport sink   (input valid, status, key_out, entry_valid, entry_count, output ready);
endinterface

@@ rtl/mtf_ram.sv @@
// ----------------------------------------------------------------------------
// mtf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mtf_ram #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/mtf_seq.sv @@
// ----------------------------------------------------------------------------
// mtf_seq
// Sequencer: one key compare / one entry move per cycle over the key RAM,
// fill count and registered response.
// ----------------------------------------------------------------------------
module mtf_seq
  import mtf_pkg::*;
#(
  parameter int  CAPACITY = MTF_CAPACITY,
  localparam int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int FW       = $clog2(CAPACITY + 1)
) (
  input  logic             clk,
  input  logic             rst,
  mtf_in_if.sink           req,
  mtf_out_if.source        rsp,
  output logic             ram_we,
  output logic [AW-1:0]    ram_waddr,
  output logic [KEY_W-1:0] ram_wdata,
  output logic             ram_re,
  output logic [AW-1:0]    ram_raddr,
  input  logic [KEY_W-1:0] ram_rdata
);

  localparam int CW = (FW > POS_W) ? FW : POS_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RDWAIT,
    S_SEARCH,
    S_SHIFT,
    S_HEAD
  } state_t;

  state_t           state, state_next;
  logic [AW-1:0]    idx, idx_next;
  logic [FW-1:0]    fill, fill_next;
  logic [KEY_W-1:0] key_r, key_r_next;

  logic             accept;
  logic             pos_hit;
  logic             last;
  logic             full;
  logic             fin;
  status_t          fin_status;
  logic [KEY_W-1:0] fin_key;
  logic             fin_valid;

  assign req.ready = (state == S_IDLE) && (!rsp.valid || rsp.ready);
  assign accept    = req.valid && req.ready;
  assign pos_hit   = CW'(req.position) < CW'(fill);
  assign last      = (FW'(idx) + FW'(1)) == fill;
  assign full      = fill == FW'(CAPACITY);

  always_comb begin
    state_next = state;
    idx_next   = idx;
    fill_next  = fill;
    key_r_next = key_r;
    ram_we     = 1'b0;
    ram_waddr  = idx;
    ram_wdata  = key_r;
    ram_re     = 1'b0;
    ram_raddr  = idx;
    fin        = 1'b0;
    fin_status = ST_READ;
    fin_key    = '0;
    fin_valid  = 1'b0;

    case (state)
      S_IDLE: begin
        if (accept) begin
          key_r_next = req.key;
          case (req.func)
            FN_ADD: begin
              if (fill == '0) begin
                ram_we     = 1'b1;
                ram_waddr  = '0;
                ram_wdata  = req.key;
                fill_next  = FW'(1);
                fin        = 1'b1;
                fin_status = ST_ADDED;
              end else begin
                ram_re     = 1'b1;
                ram_raddr  = '0;
                idx_next   = '0;
                state_next = S_SEARCH;
              end
            end
            FN_CLEAR: begin
              fill_next  = '0;
              fin        = 1'b1;
              fin_status = ST_CLEARED;
            end
            default: begin
              // read; position past the filled part answers at once
              if (pos_hit) begin
                ram_re     = 1'b1;
                ram_raddr  = AW'(req.position);
                state_next = S_RDWAIT;
              end else begin
                fin        = 1'b1;
                fin_status = ST_READ;
              end
            end
          endcase
        end
      end

      S_RDWAIT: begin
        fin        = 1'b1;
        fin_status = ST_READ;
        fin_key    = ram_rdata;
        fin_valid  = 1'b1;
        state_next = S_IDLE;
      end

      S_SEARCH: begin
        // ram_rdata holds entry idx
        if (ram_rdata == key_r) begin
          if (idx == '0) begin
            fin        = 1'b1;
            fin_status = ST_DUP;
            state_next = S_IDLE;
          end else begin
            ram_re     = 1'b1;
            ram_raddr  = idx - AW'(1);
            state_next = S_SHIFT;
          end
        end else if (last) begin
          if (full) begin
            fin        = 1'b1;
            fin_status = ST_FULL;
          end else begin
            ram_we     = 1'b1;
            ram_waddr  = AW'(fill);
            ram_wdata  = key_r;
            fill_next  = fill + FW'(1);
            fin        = 1'b1;
            fin_status = ST_ADDED;
          end
          state_next = S_IDLE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = idx + AW'(1);
          idx_next  = idx + AW'(1);
        end
      end

      S_SHIFT: begin
        // ram_rdata holds entry idx-1; move it down one place
        ram_we    = 1'b1;
        ram_waddr = idx;
        ram_wdata = ram_rdata;
        if (idx == AW'(1)) begin
          state_next = S_HEAD;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = idx - AW'(2);
          idx_next  = idx - AW'(1);
        end
      end

      S_HEAD: begin
        ram_we     = 1'b1;
        ram_waddr  = '0;
        ram_wdata  = key_r;
        fin        = 1'b1;
        fin_status = ST_DUP;
        state_next = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      rsp.valid <= 1'b0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      if (fin) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
    idx   <= idx_next;
    key_r <= key_r_next;
    if (fin) begin
      rsp.status      <= fin_status;
      rsp.key_out     <= fin_key;
      rsp.entry_valid <= fin_valid;
      rsp.entry_count <= CNT_W'(fill_next);
    end
  end

endmodule

@@ rtl/move_to_front_key_table_top.sv @@
// ----------------------------------------------------------------------------
// move_to_front_key_table_top
// Bounded table of distinct 48-bit keys with move-to-front on duplicates.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                    | transfer
//  --------+-----+--------------------------------------------+-----------------
//  req     | in  | func, key, position                        | valid && ready
//  rsp     | out | status, key_out, entry_valid, entry_count  | valid && ready
//
//  Requests are served one at a time. Clear, out-of-range read and add to an
//  empty table answer from idle; a read waits on the registered RAM data;
//  other adds search from the head, then append, reject as full, or move a
//  duplicate to the head, moving those ahead of it. Search and shift run on the
//  single read port of the key RAM, one entry a cycle.
//  Reset clears the count, the state and rsp.valid; the key RAM is never cleared.
//  req.ready drops while a request is in work or a response is stalled.
// ----------------------------------------------------------------------------
module move_to_front_key_table_top
  import mtf_pkg::*;
#(
  parameter int CAPACITY = MTF_CAPACITY
) (
  input logic       clk,
  input logic       rst,
  mtf_in_if.sink    req,
  mtf_out_if.source rsp
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  // key RAM port
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [KEY_W-1:0] ram_wdata;
  logic             ram_re;
  logic [AW-1:0]    ram_raddr;
  logic [KEY_W-1:0] ram_rdata;

  // sequencer: search, shift, append, and the response register
  mtf_seq #(
    .CAPACITY (CAPACITY)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  // key store, head at address 0
  mtf_ram #(
    .WIDTH (KEY_W),
    .DEPTH (CAPACITY)
  ) u_keys (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ---- checks ----

  // a new request is only taken when the response slot frees this cycle
  a_ready_slot: assert property (@(posedge clk) disable iff (rst)
    req.ready && rsp.valid |-> rsp.ready)
    else $error("request taken with response slot blocked");

  // only reads return a key
  a_valid_read: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.entry_valid |-> rsp.status == ST_READ)
    else $error("entry_valid set on a non-read response");

  // after an append the table is not empty
  a_add_count: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status == ST_ADDED |-> CAPACITY > 127 || rsp.entry_count != '0)
    else $error("add reported with empty table");

  // clear always reports an empty table
  a_clear_count: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status == ST_CLEARED |-> rsp.entry_count == '0)
    else $error("clear reported non-zero count");

endmodule

@@ test/mtf_checker.sv @@
// ----------------------------------------------------------------------------
// mtf_checker
// Watches the request and response channels of the key table, keeps its own
// copy of the table, and compares every response with the predicted one.
// ----------------------------------------------------------------------------
module mtf_checker
  import mtf_pkg::*;
#(
  parameter int CAPACITY = MTF_CAPACITY
) (
  input  logic clk,
  input  logic rst,
  mtf_in_if    req,
  mtf_out_if   rsp,
  output int   fail_count,
  output int   results_owed
);

  typedef struct packed {
    status_t          status;
    logic [KEY_W-1:0] key_out;
    logic             entry_valid;
    logic [CNT_W-1:0] entry_count;
  } table_reply_t;

  logic [KEY_W-1:0] key_table [CAPACITY];
  int               table_fill;
  table_reply_t     replies_due [$];
  table_reply_t     due;

  function automatic void log_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endfunction

  // one request against the shadow table; returns the response it must give
  function automatic table_reply_t apply_request(logic [FUNC_W-1:0] fn,
                                                 logic [KEY_W-1:0]  k,
                                                 logic [POS_W-1:0]  p);
    table_reply_t r;
    int           hit;
    r   = '0;
    hit = -1;
    if (fn == FN_ADD) begin
      for (int i = 0; i < table_fill; i++)
        if (hit < 0 && key_table[i] == k) hit = i;
      if (hit >= 0) begin
        // entries ahead of the hit slide back by one
        for (int j = hit; j > 0; j--) key_table[j] = key_table[j-1];
        key_table[0] = k;
        r.status = ST_DUP;
      end else if (table_fill >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        key_table[table_fill] = k;
        table_fill++;
        r.status = ST_ADDED;
      end
    end else if (fn == FN_CLEAR) begin
      table_fill = 0;
      r.status   = ST_CLEARED;
    end else begin
      // bit 1 of the code selects a read
      r.status = ST_READ;
      if (int'(p) < table_fill && int'(p) < CAPACITY) begin
        r.key_out     = key_table[p];
        r.entry_valid = 1'b1;
      end
    end
    r.entry_count = CNT_W'(table_fill);
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      table_fill = 0;
      fail_count = 0;
      replies_due.delete();
    end else begin
      if (req.valid && req.ready)
        replies_due.push_back(apply_request(req.func, req.key, req.position));
      if (rsp.valid && rsp.ready) begin
        if (replies_due.size() == 0) begin
          log_failure($sformatf("response with none outstanding: status %0d key_out %h",
                                rsp.status, rsp.key_out));
        end else begin
          due = replies_due.pop_front();
          if (due.status !== rsp.status || due.key_out !== rsp.key_out ||
              due.entry_valid !== rsp.entry_valid ||
              due.entry_count !== rsp.entry_count)
            log_failure($sformatf({"mismatch (exp/got): status %0d/%0d key_out %h/%h",
                                   " entry_valid %0d/%0d entry_count %0d/%0d"},
                                  due.status, rsp.status, due.key_out, rsp.key_out,
                                  due.entry_valid, rsp.entry_valid,
                                  due.entry_count, rsp.entry_count));
        end
      end
    end
    results_owed = replies_due.size();
  end

endmodule

@@ test/move_to_front_key_table_top_tb.sv @@
// ----------------------------------------------------------------------------
// move_to_front_key_table_top_tb
// Drives adds, clears and reads into the key table with random gaps and
// response stalls; a checker beside the block predicts every response.
// ----------------------------------------------------------------------------
module move_to_front_key_table_top_tb;
  import mtf_pkg::*;

  // Read is any code with bit 1 set; 3 is the reserved alias of 2.
  localparam logic [FUNC_W-1:0] FN_READ     = 2'd2;
  localparam logic [FUNC_W-1:0] FN_READ_ALT = 2'd3;

  localparam int RANDOM_ITEMS = 1300;
  localparam int POOL_SIZE    = 96;    // more keys than slots, so full is reached
  localparam int HOLD_CYCLES  = 400;   // long response stall
  localparam int DRAIN_CYCLES = 300;   // outlasts the worst request
  // worst item plus stalls on both sides, times ~1450 items, with ample headroom
  localparam int CYCLE_LIMIT  = 1_000_000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  mtf_in_if  req_ch ();
  mtf_out_if rsp_ch ();

  int fail_count;
  int results_owed;
  int cycle_count;
  int items_sent;
  bit idle_on;    // random gaps on both sides
  bit hold_rsp;   // asks the receiver for one long stall

  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  move_to_front_key_table_top #(
    .CAPACITY (MTF_CAPACITY)
  ) DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  mtf_checker #(
    .CAPACITY (MTF_CAPACITY)
  ) u_checker (
    .clk          (clk),
    .rst          (rst),
    .req          (req_ch),
    .rsp          (rsp_ch),
    .fail_count   (fail_count),
    .results_owed (results_owed)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 0;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL move_to_front_key_table_top");
      $finish;
    end
  end

  function automatic logic [KEY_W-1:0] rand_key();
    return KEY_W'({$urandom, $urandom});
  endfunction

  function automatic logic [POS_W-1:0] rand_pos();
    return POS_W'($urandom);
  endfunction

  // Offers one request and returns at the edge where it transferred.
  // valid stays high into the next call unless a gap is drawn, so a
  // back-to-back request never sees valid dropped and raised in one step.
  task automatic send_op(input logic [FUNC_W-1:0] fn, input logic [KEY_W-1:0] k,
                         input logic [POS_W-1:0] p);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.func     <= fn;
    req_ch.key      <= k;
    req_ch.position <= p;
    do @(posedge clk); while (!req_ch.ready);
    items_sent++;
  endtask

  // Sender goes quiet until every outstanding response has come back.
  // One edge first, so the checker has counted the last transfer.
  task automatic wait_for_replies();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    wait (results_owed == 0);
    @(posedge clk);
  endtask

  // Mostly pool keys, so duplicates are common; some fresh keys and reads,
  // and the odd clear to reset the fill level.
  task automatic random_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 2)
      send_op(FN_CLEAR, rand_key(), rand_pos());
    else if (r < 55)
      send_op(FN_ADD, key_pool[$urandom_range(0, POOL_SIZE-1)], rand_pos());
    else if (r < 65)
      send_op(FN_ADD, rand_key(), rand_pos());
    else
      send_op(($urandom_range(0, 3) == 0) ? FN_READ_ALT : FN_READ, rand_key(), rand_pos());
  endtask

  // Clear, fill past capacity (tail slots rejected), then work the full
  // table: duplicates still move to the head, new keys bounce.
  task automatic fill_phase();
    foreach (key_pool[i]) key_pool[i] = rand_key();
    send_op(FN_CLEAR, rand_key(), rand_pos());
    for (int i = 0; i < MTF_CAPACITY + 6; i++)
      send_op(FN_ADD, key_pool[i], rand_pos());
    send_op(FN_READ, rand_key(), POS_W'(MTF_CAPACITY - 1));
    repeat (24) random_op();
  endtask

  // Receiver: random stall bursts, or one long hold when asked. The hold
  // is counted here so the sender keeps offering and the block backs up.
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_rsp) begin
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rsp = 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    int target;
    req_ch.valid    = 1'b0;
    req_ch.func     = FN_ADD;
    req_ch.key      = '0;
    req_ch.position = '0;
    idle_on         = 1'b1;
    hold_rsp        = 1'b0;
    cycle_count     = 0;
    items_sent      = 0;
    foreach (key_pool[i]) key_pool[i] = '0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // --- directed ---
    // reads of an empty table, incl. the reserved code at the last position
    send_op(FN_READ,     '0, '0);
    send_op(FN_READ_ALT, '1, '1);
    // extreme keys
    send_op(FN_ADD, '0, '0);
    send_op(FN_ADD, '1, '1);
    send_op(FN_ADD, 48'hAAAA_AAAA_AAAA, '0);
    send_op(FN_ADD, 48'h5555_5555_5555, '1);
    // duplicate from the middle, then the same key again while at the head
    send_op(FN_ADD, '1, '0);
    send_op(FN_ADD, '1, '0);
    send_op(FN_READ,     '0, 6'd0);
    send_op(FN_READ_ALT, '0, 6'd3);
    send_op(FN_READ,     '1, 6'd4);    // just past the fill level
    // duplicate in the second slot, just behind the head
    send_op(FN_ADD, '0, '1);
    send_op(FN_READ, '1, '1);
    // clear with junk in the unused fields, then use the empty table again
    send_op(FN_CLEAR, '1, '1);
    send_op(FN_READ, '0, '0);
    send_op(FN_ADD, 48'h0000_0000_0001, '0);
    wait_for_replies();

    // receiver holds off while the sender keeps offering
    hold_rsp = 1'b1;
    repeat (12) random_op();
    wait_for_replies();

    fill_phase();

    // --- random phases ---
    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      // no idling in the tail of the run
      idle_on = (items_sent < target - 150) && ($urandom_range(0, 3) != 0);
      if (idle_on && $urandom_range(0, 9) == 0) hold_rsp = 1'b1;
      if ($urandom_range(0, 3) == 0)
        fill_phase();
      else
        repeat ($urandom_range(20, 80)) random_op();
      if (idle_on && $urandom_range(0, 7) == 0) wait_for_replies();
    end

    wait_for_replies();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && results_owed == 0)
      $display("PASS move_to_front_key_table_top");
    else
      $display("FAIL move_to_front_key_table_top");
    $finish;
  end

endmodule
